// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/twwa_pkg.sv -----
// Package with shared constants, types and codes of the window average unit.
`timescale 1ns / 1ps
package twwa_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 7;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int SMP_W      = 16;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 3;
    localparam int SUM_W      = 32;
    localparam int WSUM_W     = 14;
    localparam int AVG_W      = 24;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS_Y    = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd4;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture item and set up window bounds
        logic store;     // write sample to memory
        logic rd_center; // issue read of the centre pixel
        logic lat_center;// latch centre read data
        logic rd_nbr;    // issue read of the current neighbor, step window
        logic acc;       // accumulate the neighbor read last cycle
        logic div_start; // start the divider
        logic div_step;  // one restoring division step
        logic finish;    // form the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_store;
        logic in_grid;
        logic last_nbr;
        logic wsum_zero;
        logic div_done;
    } t_stat;
endpackage

// ----- rtl/twwa_ctrl.sv -----
// Controller state machine of the window average unit.
`timescale 1ns / 1ps
module twwa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  twwa_pkg::t_stat  i_stat,
    output twwa_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CRD  = 3'd1;
    localparam logic [2:0] S_CLAT = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    // A new item is taken whenever idle; a pending result only holds back the finish step.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CRD;
                end
            end
            S_CRD: begin
                if (i_stat.is_store) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end else if (!i_stat.in_grid) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_center = 1'b1;
                    n_state         = S_CLAT;
                end
            end
            S_CLAT: begin
                // The first neighbor read goes out while the centre is latched.
                o_cmd.lat_center = 1'b1;
                o_cmd.rd_nbr     = 1'b1;
                if (i_stat.last_nbr) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.rd_nbr = 1'b1;
                o_cmd.acc    = 1'b0;
                if (i_stat.last_nbr) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.acc = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_stat.wsum_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (!r_ovalid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Accumulation of the previous neighbor read overlaps the walk.
        if (r_state == S_WALK) begin
            o_cmd.acc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ----- rtl/twwa_dp.sv -----
// Datapath of the window average unit: configuration, pixel memory, accumulator, divider.
`timescale 1ns / 1ps
module twwa_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [twwa_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [twwa_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_operation,
    input  logic [twwa_pkg::COL_W-1:0]            i_col,
    input  logic [twwa_pkg::ROW_W-1:0]            i_row,
    input  logic signed [twwa_pkg::SMP_W-1:0]     i_sample,
    input  twwa_pkg::t_cmd                        i_cmd,
    output twwa_pkg::t_stat                       o_stat,
    output logic [twwa_pkg::COL_W-1:0]            o_out_col,
    output logic [twwa_pkg::ROW_W-1:0]            o_out_row,
    output logic signed [twwa_pkg::AVG_W-1:0]     o_average,
    output logic                                  o_valid_res
);
    localparam int CW = twwa_pkg::COL_W;
    localparam int RW = twwa_pkg::ROW_W;
    localparam int SW = twwa_pkg::SMP_W;
    localparam int SUMW = twwa_pkg::SUM_W;
    localparam int WW = twwa_pkg::WSUM_W;
    localparam int NW = SUMW + 9;   // magnitude*512 + wsum
    localparam int DW = WW + 1;     // wsum*2
    localparam int AVG_W = twwa_pkg::AVG_W;

    // Configuration registers.
    logic [8:0]  r_gw, r_gh;
    logic [2:0]  r_rx, r_ry;
    logic [SW-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw  <= 9'd256;
            r_gh  <= 9'd256;
            r_rx  <= 3'd1;
            r_ry  <= 3'd1;
            r_thr <= 16'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                twwa_pkg::REG_GRID_WIDTH:  r_gw  <= i_cfg_data[8:0];
                twwa_pkg::REG_GRID_HEIGHT: r_gh  <= i_cfg_data[8:0];
                twwa_pkg::REG_RADIUS_X:    r_rx  <= i_cfg_data[2:0];
                twwa_pkg::REG_RADIUS_Y:    r_ry  <= i_cfg_data[2:0];
                twwa_pkg::REG_THRESHOLD:   r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped grid size (MAX is 256, so values above saturate; zero becomes 1).
    logic [8:0] w_c, h_c;
    assign w_c = (r_gw == 9'd0) ? 9'd1 : ((r_gw > 9'd256) ? 9'd256 : r_gw);
    assign h_c = (r_gh == 9'd0) ? 9'd1 : ((r_gh > 9'd256) ? 9'd256 : r_gh);

    // Item registers.
    logic          r_op;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [SW-1:0] r_smp;
    logic          r_ingrid;
    logic [2:0]    r_rxl, r_ryl;
    logic [8:0]    r_x0, r_x1, r_y1;
    logic [8:0]    r_ix, r_iy;

    logic [9:0] cx_hi, cy_hi;
    assign cx_hi = {2'b0, i_col} + {7'b0, r_rx};
    assign cy_hi = {2'b0, i_row} + {7'b0, r_ry};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_col    <= i_col;
            r_row    <= i_row;
            r_smp    <= i_sample;
            r_rxl    <= r_rx;
            r_ryl    <= r_ry;
            r_ingrid <= ({1'b0, i_col} < w_c) && ({1'b0, i_row} < h_c);
            r_x0     <= (i_col >= {5'b0, r_rx}) ? {1'b0, i_col - {5'b0, r_rx}} : 9'd0;
            r_x1     <= (cx_hi >= {1'b0, w_c}) ? w_c - 9'd1 : cx_hi[8:0];
            r_y1     <= (cy_hi >= {1'b0, h_c}) ? h_c - 9'd1 : cy_hi[8:0];
            r_ix     <= (i_col >= {5'b0, r_rx}) ? {1'b0, i_col - {5'b0, r_rx}} : 9'd0;
            r_iy     <= (i_row >= {5'b0, r_ry}) ? {1'b0, i_row - {5'b0, r_ry}} : 9'd0;
        end else if (i_cmd.rd_nbr) begin
            if (r_ix == r_x1) begin
                r_ix <= r_x0;
                r_iy <= r_iy + 9'd1;
            end else begin
                r_ix <= r_ix + 9'd1;
            end
        end
    end

    // Pixel memory, one read per cycle and at most one write in the same cycle, registered read data.
    logic [SW-1:0] mem [0:twwa_pkg::MAX_WIDTH*twwa_pkg::MAX_HEIGHT-1];
    logic [SW-1:0] r_rdata;
    logic [twwa_pkg::ADDR_W-1:0] rd_addr;
    assign rd_addr = i_cmd.rd_center ? {r_row, r_col} : {r_iy[RW-1:0], r_ix[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[{r_row, r_col}] <= r_smp;
        end
        r_rdata <= mem[rd_addr];
    end

    // Weight of the neighbor being read, registered alongside its read data.
    logic [8:0] dx, dy;
    logic [3:0] wx, wy;
    logic [6:0] r_wt;
    assign dx = (r_ix >= {1'b0, r_col}) ? r_ix - {1'b0, r_col} : {1'b0, r_col} - r_ix;
    assign dy = (r_iy >= {1'b0, r_row}) ? r_iy - {1'b0, r_row} : {1'b0, r_row} - r_iy;
    assign wx = {1'b0, r_rxl} - dx[3:0] + 4'd1;
    assign wy = {1'b0, r_ryl} - dy[3:0] + 4'd1;

    logic signed [SW-1:0] r_center;
    logic signed [SUMW-1:0] r_sum;
    logic [WW-1:0] r_wsum;
    logic signed [SW:0] diff;
    logic [SW:0] adiff;
    logic signed [SW+7:0] prod;

    assign diff  = $signed({r_rdata[SW-1], r_rdata}) - $signed({r_center[SW-1], r_center});
    assign adiff = diff[SW] ? 17'(-diff) : diff;
    assign prod  = $signed(r_rdata) * $signed({1'b0, r_wt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_nbr) begin
            r_wt <= 7'({3'b0, wx} * {3'b0, wy});
        end
        if (i_cmd.lat_center) begin
            r_center <= r_rdata;
            r_sum    <= '0;
            r_wsum   <= '0;
        end else if (i_cmd.acc && !i_cmd.lat_center && (adiff <= {1'b0, r_thr})) begin
            r_sum  <= r_sum + SUMW'(prod);
            r_wsum <= r_wsum + WW'(r_wt);
        end
    end

    // Restoring divider: q = (|sum|*512 + wsum) / (2*wsum), one bit a cycle.
    logic [NW-1:0] r_num;
    logic [DW:0]   r_rem;
    logic [5:0]    r_cnt;
    logic          r_busy, r_neg, r_done;
    logic [SUMW-1:0] mag;
    logic [DW:0] trial;
    assign mag   = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign trial = {r_rem[DW-1:0], r_num[NW-1]} - {1'b0, r_wsum, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_cmd.load) begin
            r_done <= 1'b0;
            r_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(NW);
            r_neg  <= r_sum[SUMW-1];
            r_num  <= {mag, 9'd0} + NW'(r_wsum);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (!r_busy) begin
                r_done <= 1'b1;
            end else begin
                if (!trial[DW]) begin
                    r_rem <= trial;
                    r_num <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DW-1:0], r_num[NW-1]};
                    r_num <= {r_num[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Output register.
    logic valid_now;
    assign valid_now = r_ingrid && (r_wsum != '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_col   <= r_col;
            o_out_row   <= r_row;
            o_valid_res <= valid_now;
            o_average   <= !valid_now ? '0 :
                           (r_neg ? AVG_W'(-r_num) : AVG_W'(r_num));
        end
    end

    assign o_stat.is_store  = (r_op == twwa_pkg::OP_STORE);
    assign o_stat.in_grid   = r_ingrid;
    assign o_stat.last_nbr  = (r_ix == r_x1) && (r_iy == r_y1);
    assign o_stat.wsum_zero = (r_wsum == '0);
    assign o_stat.div_done  = r_done;
endmodule

// ----- rtl/threshold_weighted_window_average_unit.sv -----
// Top level of the threshold weighted window average unit.
`timescale 1ns / 1ps
// Channel | Signals                                   | Direction
// input   | i_in_valid/o_in_ready, operation,col,row,sample | in
// output  | o_out_valid/i_out_ready, col,row,average,valid   | out
// config  | i_cfg_we, i_cfg_index, i_cfg_data                | in
//
// A store transaction writes its sample to the pixel memory. A compute transaction inside the
// grid reads the centre and every pixel of the clipped window (up to 225 pixel reads through
// the single memory port), then runs the bit-serial divider unless the weight sum is zero.
// A compute outside the grid skips the window reads and the divider.
// Reset is synchronous and active low; the pixel memory is not cleared.
// A pending result waits in the output register while the next transaction is taken;
// a compute that finishes before that result leaves waits in its last step.
module threshold_weighted_window_average_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [twwa_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [twwa_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [twwa_pkg::COL_W-1:0]        i_col,
    input  logic [twwa_pkg::ROW_W-1:0]        i_row,
    input  logic signed [twwa_pkg::SMP_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [twwa_pkg::COL_W-1:0]        o_out_col,
    output logic [twwa_pkg::ROW_W-1:0]        o_out_row,
    output logic signed [twwa_pkg::AVG_W-1:0] o_average,
    output logic                              o_valid_res
);
    twwa_pkg::t_cmd  cmd;
    twwa_pkg::t_stat stat;

    // The controller sequences each transaction; the datapath does the work.
    twwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    twwa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_average   (o_average),
        .o_valid_res (o_valid_res)
    );
endmodule

// ----- rtl/twwa_checker.sv -----
// Port-level checker for the window average unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twwa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_valid_res,
    input logic signed [twwa_pkg::AVG_W-1:0] o_average
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped")
    `CHK_IMPL(a_inval_zero, i_clk, i_rst_n, o_out_valid && !o_valid_res, o_average == '0, "nonzero average")
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready right after accept")
endmodule

bind threshold_weighted_window_average_unit twwa_checker u_twwa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_valid_res (o_valid_res),
    .o_average   (o_average)
);
